>>> rtl/hill_cipher_block_defines.svh
// Assertion macros for the Hill cipher block.
// Included by the top level; uses the clk and rst names of the including module.
`ifndef HILL_CIPHER_BLOCK_DEFINES_SVH
`define HILL_CIPHER_BLOCK_DEFINES_SVH

`ifndef SYNTHESIS
`define HCB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hill_cipher_block assertion failed");
`define HCB_NEVER(label, expr) \
  `HCB_ASSERT(label, !(expr))
`else
`define HCB_ASSERT(label, prop)
`define HCB_NEVER(label, expr)
`endif

`endif

>>> rtl/hcb_pkg.sv
// Shared types, constants and functions of the Hill cipher block.
// No dependencies; imported by every module of the block.
`default_nettype none
package hcb_pkg;

  localparam int MaxDim     = 5;
  localparam int KeyRows    = 5;
  localparam int LetterW    = 5;
  localparam int DimW       = 3;
  localparam int KeyW       = KeyRows * LetterW;
  localparam int CfgIdxW    = 3;
  localparam int SumW       = 13;
  localparam int RecipW     = 12;
  localparam int RecipShift = 16;
  localparam int QDepth     = 2;
  localparam int QPtrW      = 1;
  localparam int QCntW      = 2;

  localparam logic [SumW-1:0]    Alpha     = SumW'(26);
  localparam logic [RecipW-1:0]  Recip     = RecipW'(2521);
  localparam logic [LetterW-1:0] PadLetter = LetterW'(23);

  localparam logic [CfgIdxW-1:0] CfgBlockSize = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyRow0   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyRow1   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyRow2   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgKeyRow3   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgKeyRow4   = 3'd5;

  typedef struct packed {
    logic [LetterW-1:0] letter_in;
    logic               end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [LetterW-1:0] letter_out;
    logic               last_of_block;
    logic               last_of_message;
  } out_item_t;

  typedef struct packed {
    logic [MaxDim-1:0][LetterW-1:0] letters;
    logic [DimW-1:0]                size;
    logic                           eom;
  } block_t;

  typedef logic [KeyRows-1:0][KeyW-1:0] key_mat_t;

  function automatic logic [DimW-1:0] eff_size(input logic [DimW-1:0] bs);
    logic [DimW-1:0] n;
    n = bs;
    if (n == '0) n = DimW'(1);
    if (n > DimW'(MaxDim)) n = DimW'(MaxDim);
    return n;
  endfunction

  function automatic logic [LetterW-1:0] mod_alpha(input logic [SumW-1:0] x);
    logic [SumW+RecipW-1:0] prod;
    logic [SumW-1:0]        q;
    logic [SumW-1:0]        r;
    prod = (SumW+RecipW)'(x) * (SumW+RecipW)'(Recip);
    q    = SumW'(prod >> RecipShift);
    r    = x - SumW'(q * Alpha);
    return r[LetterW-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/hcb_front.sv
// Front end: gathers letters into a block and hands full or flushed blocks on.
// Depends on hcb_pkg.
`default_nettype none
module hcb_front import hcb_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire in_item_t        item,
  input  wire logic [DimW-1:0] block_size,
  input  wire logic            q_full,
  output logic                 q_push,
  output block_t               q_data
);

  logic [DimW-1:0]                fill;
  logic [DimW-1:0]                fill_next;
  logic [DimW-1:0]                fill_inc;
  logic [DimW-1:0]                n;
  logic [MaxDim-1:0][LetterW-1:0] letters;
  logic                           accept;
  logic                           flush;

  assign accept   = push && !q_full;
  assign fill_inc = fill + DimW'(1);
  assign n        = eff_size(block_size);
  assign flush    = accept && ((fill_inc >= n) || item.end_of_message);
  assign q_push   = flush;

  always_comb begin
    for (int k = 0; k < MaxDim; k++) begin
      if (DimW'(k) < fill_inc) begin
        q_data.letters[k] = (DimW'(k) == fill) ? item.letter_in : letters[k];
      end else begin
        q_data.letters[k] = PadLetter;
      end
    end
    q_data.size = n;
    q_data.eom  = item.end_of_message;
  end

  always_comb begin
    fill_next = fill;
    if (flush) begin
      fill_next = '0;
    end else if (accept) begin
      fill_next = fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (fill < DimW'(MaxDim))) begin
      letters[fill] <= item.letter_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/hcb_queue.sv
// Short block queue between the front end and the matrix unit.
// Depends on hcb_pkg.
`default_nettype none
module hcb_queue import hcb_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr,
  input  wire block_t wr_data,
  input  wire logic   rd,
  output block_t      rd_data,
  output logic        full,
  output logic        valid
);

  block_t             entries [QDepth];
  logic [QPtrW-1:0]   wr_ptr;
  logic [QPtrW-1:0]   rd_ptr;
  logic [QCntW-1:0]   count;
  logic [QCntW-1:0]   count_next;

  assign full    = (count == QCntW'(QDepth));
  assign valid   = (count != '0);
  assign rd_data = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr && !rd) begin
      count_next = count + QCntW'(1);
    end else if (rd && !wr) begin
      count_next = count - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + QPtrW'(1);
      if (rd) rd_ptr <= rd_ptr + QPtrW'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/hcb_back.sv
// Matrix unit: key row per unstalled cycle, sum stage, mod 26 output stage.
// Depends on hcb_pkg.
`default_nettype none
module hcb_back import hcb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire block_t   blk,
  input  wire logic     blk_valid,
  output logic          blk_pop,
  input  wire key_mat_t keys,
  input  wire logic     pop,
  output logic          out_valid,
  output out_item_t     out_item
);

  logic [DimW-1:0] row;
  logic [DimW-1:0] row_next;
  logic            s1_valid;
  logic [SumW-1:0] s1_sum;
  logic            s1_lob;
  logic            s1_lom;
  logic            out_ready;
  logic            s1_ready;
  logic            issue;
  logic            last;
  logic [KeyW-1:0] key_row;
  logic [SumW-1:0] sum;

  assign out_ready = !out_valid || pop;
  assign s1_ready  = !s1_valid || out_ready;
  assign issue     = blk_valid && s1_ready;
  assign last      = (row == (blk.size - DimW'(1)));
  assign blk_pop   = issue && last;
  assign key_row   = keys[row];

  always_comb begin
    sum = '0;
    for (int k = 0; k < MaxDim; k++) begin
      if (DimW'(k) < blk.size) begin
        sum = sum + SumW'(key_row[k*LetterW +: LetterW]) * SumW'(blk.letters[k]);
      end
    end
  end

  always_comb begin
    row_next = row;
    if (issue) begin
      row_next = last ? '0 : row + DimW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      row <= row_next;
      if (s1_ready) s1_valid <= issue;
      if (out_ready) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_sum <= sum;
      s1_lob <= last;
      s1_lom <= last && blk.eom;
    end
    if (out_ready && s1_valid) begin
      out_item.letter_out      <= mod_alpha(s1_sum);
      out_item.last_of_block   <= s1_lob;
      out_item.last_of_message <= s1_lom;
    end
  end

endmodule
`default_nettype wire

>>> rtl/hill_cipher_block.sv
// Hill cipher mod 26 top level: configuration registers, front end, queue, matrix unit.
// Takes one letter per cycle unless full; a full or flushed block of n letters gives n
// results through the queue, sum and output stages, one per cycle while they are popped.
// Unless pop stalls it, the matrix unit does one key row, so one result, per cycle.
// Synchronous reset sets block size 2, the identity key and an empty block.
`default_nettype none
`include "hill_cipher_block_defines.svh"
module hill_cipher_block import hcb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire in_item_t           item,
  output logic                    empty,
  input  wire logic               pop,
  output out_item_t               result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [KeyW-1:0]    cfg_data
);

  logic [DimW-1:0] block_size;
  key_mat_t        keys;
  logic            q_push;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  block_t          q_wr_data;
  block_t          q_rd_data;
  logic            out_valid;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= DimW'(2);
      for (int r = 0; r < KeyRows; r++) begin
        keys[r] <= KeyW'(1) << (r * LetterW);
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgBlockSize: block_size <= cfg_data[DimW-1:0];
        CfgKeyRow0:   keys[0] <= cfg_data;
        CfgKeyRow1:   keys[1] <= cfg_data;
        CfgKeyRow2:   keys[2] <= cfg_data;
        CfgKeyRow3:   keys[3] <= cfg_data;
        CfgKeyRow4:   keys[4] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  hcb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .block_size (block_size),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wr_data)
  );

  hcb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .valid   (q_valid)
  );

  hcb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .blk       (q_rd_data),
    .blk_valid (q_valid),
    .blk_pop   (q_pop),
    .keys      (keys),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (result)
  );

  `HCB_NEVER(a_queue_overflow, q_push && q_full)
  `HCB_NEVER(a_queue_underflow, q_pop && !q_valid)
  `HCB_ASSERT(a_letter_range, !empty |-> result.letter_out < 26)
  `HCB_ASSERT(a_msg_ends_block, !empty && result.last_of_message |-> result.last_of_block)

endmodule
`default_nettype wire

>>> verif/hcb_cipher_checker.sv
`timescale 1ns / 100ps
// Checker for the Hill cipher block: follows the letter, result and register channels.
// It predicts each encrypted letter and compares it with what the block sends out.
// Depends on hcb_pkg for the item types and register indexes.
module hcb_cipher_checker import hcb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  in_item_t            item,
  input  logic                pop,
  input  logic                empty,
  input  out_item_t           result,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [KeyW-1:0]     cfg_data,
  output int                  mismatches,
  output int                  pending
);

  logic [DimW-1:0]    dim_reg;
  logic [KeyW-1:0]    key_row [KeyRows];
  logic [LetterW-1:0] held_letters [MaxDim];
  logic [DimW-1:0]    held_count;
  out_item_t          cipher_letters_q [$];
  int                 bad_count;

  function automatic int block_dim();
    int n;
    n = int'(dim_reg);
    if (n < 1) n = 1;
    if (n > MaxDim) n = MaxDim;
    return n;
  endfunction

  task automatic encrypt_letter(input in_item_t it);
    int                 n;
    int                 acc;
    logic [LetterW-1:0] column [MaxDim];
    out_item_t          ct;
    n = block_dim();
    if (held_count < MaxDim) held_letters[held_count] = it.letter_in;
    held_count = held_count + 1'b1;
    if (held_count < n && !it.end_of_message) return;
    for (int k = 0; k < n; k++) begin
      column[k] = (k < held_count) ? held_letters[k] : PadLetter;
    end
    for (int r = 0; r < n; r++) begin
      acc = 0;
      for (int k = 0; k < n; k++) begin
        acc += int'(key_row[r][LetterW*k +: LetterW]) * int'(column[k]);
      end
      ct.letter_out      = LetterW'(acc % 26);
      ct.last_of_block   = (r == n - 1);
      ct.last_of_message = it.end_of_message && (r == n - 1);
      cipher_letters_q.push_back(ct);
    end
    held_count = '0;
  endtask

  task automatic check_letter(input out_item_t got);
    out_item_t want;
    if (cipher_letters_q.size() == 0) begin
      if (bad_count < 10) begin
        $display("unexpected item: letter %0d block %0b message %0b",
                 got.letter_out, got.last_of_block, got.last_of_message);
      end
      bad_count++;
      return;
    end
    want = cipher_letters_q.pop_front();
    if (got.letter_out !== want.letter_out || got.last_of_block !== want.last_of_block ||
        got.last_of_message !== want.last_of_message) begin
      if (bad_count < 10) begin
        $display("mismatch: expected letter %0d block %0b message %0b, got %0d %0b %0b",
                 want.letter_out, want.last_of_block, want.last_of_message,
                 got.letter_out, got.last_of_block, got.last_of_message);
      end
      bad_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dim_reg = DimW'(2);
      for (int r = 0; r < KeyRows; r++) key_row[r] = KeyW'(1) << (LetterW * r);
      for (int k = 0; k < MaxDim; k++) held_letters[k] = '0;
      held_count = '0;
      cipher_letters_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgBlockSize: dim_reg = cfg_data[DimW-1:0];
          CfgKeyRow0, CfgKeyRow1, CfgKeyRow2, CfgKeyRow3, CfgKeyRow4: begin
            key_row[cfg_index - CfgKeyRow0] = cfg_data;
          end
          default: ;
        endcase
      end
      if (push && !full) encrypt_letter(item);
      if (pop && !empty) check_letter(result);
    end
    pending <= cipher_letters_q.size();
    mismatches <= bad_count;
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the Hill cipher block: clock, reset, letter and register stimulus.
// Instantiates hill_cipher_block and hcb_cipher_checker; depends on hcb_pkg.
module tb_top;
  import hcb_pkg::*;

  localparam int CycleLimit = 200000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  in_item_t           item = '0;
  logic               pop = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgBlockSize;
  logic [KeyW-1:0]    cfg_data = '0;
  logic               full;
  logic               empty;
  logic               cfg_ready;
  out_item_t          result;
  int                 mismatches;
  int                 pending;
  logic               calm = 1'b0;

  hill_cipher_block dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hcb_cipher_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .pop(pop), .empty(empty), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("tb_top failed");
    $finish;
  end

  task automatic send_letter(input logic [LetterW-1:0] letter, input logic eom);
    while (!calm && $urandom_range(0, 99) < 25) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{letter_in: letter, end_of_message: eom};
    do @(posedge clk); while (full);
  endtask

  // The sender holds off until every predicted letter has come out, then gives
  // the block time to finish with any item that produced no result.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [KeyW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_size(input logic [DimW-1:0] size);
    write_reg(CfgBlockSize, KeyW'(size));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [LetterW-1:0] letter;
    logic [DimW-1:0]    sizes [6];
    sizes = '{3'd1, 3'd5, 3'd4, 3'd3, 3'd7, 3'd2};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Identity key after reset, letters above 25 and a padded partial block.
    send_letter(5'd0, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd31, 1'b1);
    send_letter(5'd26, 1'b0);
    send_letter(5'd5, 1'b1);
    settle();

    write_size(3'd5);
    write_reg(CfgKeyRow0, 25'h1FFFFFF);
    write_reg(CfgKeyRow1, 25'h0);
    write_reg(CfgKeyRow2, {5'd26, 5'd27, 5'd28, 5'd29, 5'd30});
    write_reg(CfgKeyRow3, {5{5'd25}});
    write_reg(CfgKeyRow4, {5'd3, 5'd1, 5'd4, 5'd1, 5'd5});
    cfg_valid <= 1'b0;
    repeat (5) send_letter(5'd25, 1'b0);
    send_letter(5'd1, 1'b0);
    send_letter(5'd2, 1'b0);
    send_letter(5'd3, 1'b0);
    settle();

    // Block size lowered while three letters are held.
    write_size(3'd2);
    send_letter(5'd4, 1'b0);
    settle();

    write_size(3'd0);
    send_letter(5'd7, 1'b0);
    send_letter(5'd31, 1'b1);
    settle();

    write_size(3'd7);
    send_letter(5'd1, 1'b1);
    send_letter(5'd16, 1'b0);
    send_letter(5'd8, 1'b0);
    send_letter(5'd4, 1'b0);
    send_letter(5'd2, 1'b0);
    send_letter(5'd30, 1'b1);
    settle();

    write_size(3'd6);
    send_letter(5'd10, 1'b0);
    send_letter(5'd21, 1'b1);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CfgBlockSize, KeyW'(sizes[ph]));
      for (int r = 0; r < KeyRows; r++) begin
        write_reg(CfgKeyRow0 + CfgIdxW'(r), KeyW'($urandom));
      end
      cfg_valid <= 1'b0;
      calm <= (ph == 2 || ph == 3);
      for (int n = 0; n < 30; n++) begin
        letter = ($urandom_range(0, 99) < 12) ? LetterW'($urandom_range(26, 31))
                                              : LetterW'($urandom_range(0, 25));
        send_letter(letter, $urandom_range(0, 99) < 8);
      end
      settle();
    end

    calm <= 1'b0;
    send_letter(LetterW'($urandom_range(0, 25)), 1'b1);
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/hcb_pkg.sv
rtl/hcb_front.sv
rtl/hcb_queue.sv
rtl/hcb_back.sv
rtl/hill_cipher_block.sv
verif/hcb_cipher_checker.sv
verif/tb_top.sv
